// File: src/mhpq_pkg.sv
// Shared constants, types and codes of the min-heap priority queue.
package mhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int VALUE_W  = 31;
	localparam int COUNT_W  = 11;
	localparam int STATUS_W = 2;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int FILL_W   = $clog2(CAPACITY + 1);
	localparam int IDX_W    = ADDR_W + 2;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef logic [VALUE_W-1:0] value_t;
	typedef logic [ADDR_W-1:0]  addr_t;
	typedef logic [FILL_W-1:0]  fill_t;
	typedef logic [IDX_W-1:0]   idx_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_UP_CMP,
		S_POP_ROOT,
		S_POP_LAST,
		S_DN_L,
		S_DN_R,
		S_WB,
		S_RESULT
	} state_t;

endpackage

// File: src/mhpq_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module mhpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/min_heap_priority_queue.sv
// Top level of the binary min-heap priority queue: sequencer around one heap RAM.
//
//   channel | signals                                   | direction
//   cmd     | cmd_valid, cmd_stall, command, value      | in  (stall driven here)
//   res     | res_valid, res_stall, popped_value,       | out (stall driven by sink)
//           | status, entry_count                       |
//
// A push compares the new entry with its parent at each level it checks; a pop reads the root
// and the last entry, then one or two children at each level, by whether that level has one or
// two children. An entry moves at most log2 of the capacity levels. A dropped push or an empty
// pop goes straight to the result state; the next command transfers once the sequencer is idle.
// Reset clears the fill count and control state, not the heap RAM; only entries below the fill
// count are ever used. A stalled result holds in the output register while the next command runs.
module min_heap_priority_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic                        command,
	input  logic [mhpq_pkg::VALUE_W-1:0]  value,
	output logic                        res_valid,
	input  logic                        res_stall,
	output logic [mhpq_pkg::VALUE_W-1:0]  popped_value,
	output logic [mhpq_pkg::STATUS_W-1:0] status,
	output logic [mhpq_pkg::COUNT_W-1:0]  entry_count
);
	import mhpq_pkg::*;

	// Control state.
	state_t  state_q, state_d;
	fill_t   fill_q, fill_d;
	logic    res_valid_q, res_valid_d;

	// Working registers of the item in flight. The moving entry is held in val_q
	// and only written to the RAM once its final slot is known, so a swap costs a
	// single write of the displaced entry.
	addr_t   cur_q, cur_d;
	value_t  val_q, val_d;
	value_t  top_q, top_d;
	value_t  lval_q, lval_d;
	status_t stat_q, stat_d;

	// Output register.
	value_t  res_popped_q, res_popped_d;
	status_t res_status_q, res_status_d;
	logic [COUNT_W-1:0] res_count_q, res_count_d;

	// RAM port signals.
	logic    ram_we;
	addr_t   ram_waddr, ram_raddr;
	value_t  ram_wdata, ram_rdata;

	logic    cmd_fire;
	logic    out_free;
	addr_t   parent;
	idx_t    left_idx, right_idx, fill_ext;
	addr_t   child;
	value_t  child_val;
	logic    do_step;
	idx_t    next_left;

	mhpq_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_heap_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// A new command is taken only while the sequencer is idle.
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_fire  = cmd_valid && !cmd_stall;
	assign out_free  = !res_valid_q || !res_stall;

	// Heap index arithmetic around the current slot.
	assign parent    = addr_t'((cur_q - addr_t'(1)) >> 1);
	assign left_idx  = idx_t'({cur_q, 1'b1});
	assign right_idx = left_idx + idx_t'(1);
	assign fill_ext  = idx_t'(fill_q);
	assign next_left = idx_t'({child, 1'b1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			fill_q      <= fill_d;
			res_valid_q <= res_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q        <= cur_d;
		val_q        <= val_d;
		top_q        <= top_d;
		lval_q       <= lval_d;
		stat_q       <= stat_d;
		res_popped_q <= res_popped_d;
		res_status_q <= res_status_d;
		res_count_q  <= res_count_d;
	end

	always_comb begin
		state_d      = state_q;
		fill_d       = fill_q;
		cur_d        = cur_q;
		val_d        = val_q;
		top_d        = top_q;
		lval_d       = lval_q;
		stat_d       = stat_q;
		res_popped_d = res_popped_q;
		res_status_d = res_status_q;
		res_count_d  = res_count_q;
		res_valid_d  = res_valid_q && res_stall;
		ram_we       = 1'b0;
		ram_waddr    = cur_q;
		ram_wdata    = val_q;
		ram_raddr    = parent;
		child        = addr_t'(left_idx);
		child_val    = ram_rdata;
		do_step      = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (cmd_fire) begin
					top_d  = '0;
					stat_d = ST_OK;
					if (command == CMD_PUSH) begin
						if (fill_q == fill_t'(CAPACITY)) begin
							stat_d  = ST_FULL;
							state_d = S_RESULT;
						end else begin
							// The new entry starts in the first free slot.
							cur_d  = addr_t'(fill_q);
							val_d  = value;
							fill_d = fill_q + fill_t'(1);
							ram_raddr = addr_t'((addr_t'(fill_q) - addr_t'(1)) >> 1);
							state_d = (fill_q == '0) ? S_WB : S_UP_CMP;
						end
					end else begin
						if (fill_q == '0) begin
							stat_d  = ST_EMPTY;
							state_d = S_RESULT;
						end else begin
							fill_d    = fill_q - fill_t'(1);
							ram_raddr = '0;
							state_d   = S_POP_ROOT;
						end
					end
				end
			end

			S_UP_CMP: begin
				// The parent of the current slot is on the read port.
				if (val_q < ram_rdata) begin
					ram_we    = 1'b1;
					ram_wdata = ram_rdata;
					cur_d     = parent;
					ram_raddr = addr_t'((parent - addr_t'(1)) >> 1);
					state_d   = (parent == '0) ? S_WB : S_UP_CMP;
				end else begin
					ram_we  = 1'b1;
					state_d = S_RESULT;
				end
			end

			S_POP_ROOT: begin
				top_d     = ram_rdata;
				ram_raddr = addr_t'(fill_q);
				state_d   = S_POP_LAST;
			end

			S_POP_LAST: begin
				// The last entry moves to the root and sifts down from there.
				val_d     = ram_rdata;
				cur_d     = '0;
				ram_raddr = addr_t'(1);
				state_d   = (fill_ext > idx_t'(1)) ? S_DN_L : S_WB;
			end

			S_DN_L: begin
				lval_d = ram_rdata;
				if (right_idx < fill_ext) begin
					ram_raddr = addr_t'(right_idx);
					state_d   = S_DN_R;
				end else begin
					do_step = 1'b1;
				end
			end

			S_DN_R: begin
				// The right child wins a tie.
				if (lval_q < ram_rdata) begin
					child_val = lval_q;
				end else begin
					child     = addr_t'(right_idx);
					child_val = ram_rdata;
				end
				do_step = 1'b1;
			end

			S_WB: begin
				ram_we  = 1'b1;
				state_d = S_RESULT;
			end

			S_RESULT: begin
				if (out_free) begin
					res_valid_d  = 1'b1;
					res_popped_d = top_q;
					res_status_d = stat_q;
					res_count_d  = COUNT_W'(fill_q);
					state_d      = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase

		// One sift-down level: either the moving entry settles at the current slot,
		// or the chosen child moves up into it and the walk continues below.
		if (do_step) begin
			ram_we = 1'b1;
			if (val_q < child_val) begin
				state_d = S_RESULT;
			end else begin
				ram_wdata = child_val;
				cur_d     = child;
				ram_raddr = addr_t'(next_left);
				state_d   = (next_left < fill_ext) ? S_DN_L : S_WB;
			end
		end
	end

	assign res_valid    = res_valid_q;
	assign popped_value = res_popped_q;
	assign status       = res_status_q;
	assign entry_count  = res_count_q;

endmodule

// File: src/mhpq_checker.sv
// Port-level checker for the min-heap priority queue, bound to the top level.
module mhpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          cmd_valid,
	input logic                          cmd_stall,
	input logic                          res_valid,
	input logic                          res_stall,
	input logic [mhpq_pkg::VALUE_W-1:0]  popped_value,
	input logic [mhpq_pkg::STATUS_W-1:0] status,
	input logic [mhpq_pkg::COUNT_W-1:0]  entry_count
);
	import mhpq_pkg::*;

	// The block works on one command at a time.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command taken while previous one still in work");

	// A stalled result holds its payload.
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(popped_value)
			&& $stable(status) && $stable(entry_count))
		else $error("stalled result changed");

	// An empty pop leaves an empty heap and no value.
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_EMPTY |-> popped_value == '0 && entry_count == '0)
		else $error("empty pop reported a value or entries");

	// A dropped push happens only on a full heap.
	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && status == ST_FULL |->
			popped_value == '0 && entry_count == COUNT_W'(CAPACITY))
		else $error("push dropped while heap not full");

endmodule

bind min_heap_priority_queue mhpq_checker u_mhpq_checker (.*);

// File: sim/tb_top.sv
// Self-checking testbench of the min-heap priority queue: directed steps, random traffic, drain.
module tb_top;
	import mhpq_pkg::*;

	// The watchdog gives up after this many cycles in which neither channel transfers.
	// The slowest correct gap is a sender pause plus a full pop sift plus a long receiver stall,
	// and this limit leaves a wide margin over it.
	localparam int IDLE_LIMIT   = 4000;
	localparam int RANDOM_ITEMS = 600;
	// Extra wait at the end, longer than the slowest pop.
	localparam int DRAIN_CYCLES = 40;

	// One result of the block as the heap copy predicts it.
	typedef struct {
		value_t             popped;
		status_t            st;
		logic [COUNT_W-1:0] count;
	} outcome_t;

	// One row of the directed part. When known is set, want holds the result typed in by hand.
	typedef struct {
		logic     cmd;
		value_t   val;
		bit       known;
		outcome_t want;
	} step_t;

	typedef enum int {
		STALL_NONE,
		STALL_LIGHT,
		STALL_HEAVY,
		STALL_PERIODIC
	} stall_pattern_t;

	// Every input of the block starts from a known value at time zero.
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic                cmd_stall;
	logic                command   = CMD_PUSH;
	value_t              value     = '0;
	logic                res_valid;
	logic                res_stall = 1'b0;
	value_t              popped_value;
	logic [STATUS_W-1:0] status;
	logic [COUNT_W-1:0]  entry_count;

	// Private copy of the heap, updated at the moment each command transfers.
	value_t      heap_copy [CAPACITY];
	int unsigned heap_fill = 0;

	// Results the block still owes, oldest first, and the directed rows.
	outcome_t owed_results[$];
	step_t    steps[$];
	outcome_t none;
	outcome_t head;

	int             mismatches  = 0;
	int             burst_left  = 0;
	int             idle_cycles = 0;
	int             mode_left   = 0;
	int             phase_cnt   = 0;
	stall_pattern_t stall_mode  = STALL_NONE;

	min_heap_priority_queue dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.value        (value),
		.res_valid    (res_valid),
		.res_stall    (res_stall),
		.popped_value (popped_value),
		.status       (status),
		.entry_count  (entry_count)
	);

	always #2 clk = ~clk;

	// Applies one command to the heap copy and returns the result the block must give.
	// A push sifts up while strictly smaller than the parent. A pop moves the last entry
	// to the root and sifts it down toward the smaller child, the right child on a tie,
	// stopping only when the entry is strictly smaller than that child.
	function automatic outcome_t heap_apply(logic cmd, value_t val);
		outcome_t    r;
		int unsigned pos;
		int unsigned parent;
		int unsigned lchild;
		int unsigned pick;
		value_t      tmp;
		r.popped = '0;
		r.st     = ST_OK;
		if (cmd == CMD_PUSH) begin
			if (heap_fill >= CAPACITY) begin
				r.st = ST_FULL;
			end else begin
				pos = heap_fill;
				heap_copy[pos] = val;
				heap_fill++;
				while (pos > 0) begin
					parent = (pos - 1) / 2;
					if (!(heap_copy[pos] < heap_copy[parent]))
						break;
					tmp               = heap_copy[pos];
					heap_copy[pos]    = heap_copy[parent];
					heap_copy[parent] = tmp;
					pos               = parent;
				end
			end
		end else if (heap_fill == 0) begin
			r.st = ST_EMPTY;
		end else begin
			r.popped = heap_copy[0];
			heap_fill--;
			heap_copy[0] = heap_copy[heap_fill];
			pos = 0;
			while (2 * pos + 1 < heap_fill) begin
				lchild = 2 * pos + 1;
				if (lchild + 1 >= heap_fill)
					pick = lchild;
				else
					pick = (heap_copy[lchild] < heap_copy[lchild + 1]) ? lchild : lchild + 1;
				if (heap_copy[pos] < heap_copy[pick])
					break;
				tmp             = heap_copy[pos];
				heap_copy[pos]  = heap_copy[pick];
				heap_copy[pick] = tmp;
				pos             = pick;
			end
		end
		r.count = heap_fill[COUNT_W-1:0];
		return r;
	endfunction

	// Values are drawn from a few regions: a tiny range so that ties are common, the very top
	// of the range, and the whole 31-bit space.
	function automatic value_t pick_value();
		case ($urandom_range(0, 3))
			0:       return value_t'($urandom_range(0, 7));
			1:       return value_t'($urandom_range(32'h7FFF_FFF0, 32'h7FFF_FFFF));
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic add_step(logic cmd, value_t val, bit known, value_t popped, status_t st,
			int count);
		step_t s;
		s.cmd         = cmd;
		s.val         = val;
		s.known       = known;
		s.want.popped = popped;
		s.want.st     = st;
		s.want.count  = count[COUNT_W-1:0];
		steps.push_back(s);
	endtask

	// Offers one command and returns at the edge where it transfers.
	// The sender works in bursts; a new burst may open with a gap of idle cycles. The valid is
	// lowered only for such a gap, so it never gets two assignments at the same edge, and the
	// payload holds still while the block stalls.
	task automatic send(logic cmd, value_t val, bit known, outcome_t want);
		outcome_t predicted;
		int       gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
			if (gap > 0) begin
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		cmd_valid <= 1'b1;
		command   <= cmd;
		value     <= val;
		do @(posedge clk); while (cmd_stall);
		predicted = heap_apply(cmd, val);
		owed_results.push_back(known ? want : predicted);
	endtask

	// Receiver stall: a pattern that is drawn anew at random between no stall at all, light and
	// heavy random stalling, and a fixed on/off rhythm, so that stalls land on every phase of a
	// sift.
	always @(posedge clk) begin
		if (mode_left == 0) begin
			mode_left  <= $urandom_range(20, 300);
			stall_mode <= stall_pattern_t'($urandom_range(0, 3));
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			STALL_NONE:  res_stall <= 1'b0;
			STALL_LIGHT: res_stall <= ($urandom_range(0, 9) < 3);
			STALL_HEAVY: res_stall <= ($urandom_range(0, 9) < 7);
			default:     res_stall <= ((phase_cnt % 7) < 3);
		endcase
		phase_cnt <= phase_cnt + 1;
	end

	// Result checker: every result that transfers is compared field by field with the oldest
	// outstanding prediction. The outputs are sampled at the edge itself, before any update
	// scheduled at that edge takes effect.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (owed_results.size() == 0) begin
				$error("unexpected result: popped_value %0d status %0d entry_count %0d",
					popped_value, status, entry_count);
				mismatches++;
			end else begin
				head = owed_results.pop_front();
				if (popped_value !== head.popped) begin
					$error("popped_value: expected %0d, got %0d", head.popped, popped_value);
					mismatches++;
				end
				if (status !== head.st) begin
					$error("status: expected %0d, got %0d", head.st, status);
					mismatches++;
				end
				if (entry_count !== head.count) begin
					$error("entry_count: expected %0d, got %0d", head.count, entry_count);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which neither channel transfers.
	always @(posedge clk) begin
		if (!arst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int push_pct;
		// Directed part. Pops on an empty heap, the value extremes and the counts are typed in;
		// the order of the values that come out is left to the heap copy.
		add_step(CMD_POP,  31'h0,        1, 31'h0,        ST_EMPTY, 0);
		add_step(CMD_POP,  31'h7FFFFFFF, 1, 31'h0,        ST_EMPTY, 0);
		add_step(CMD_PUSH, 31'h7FFFFFFF, 1, 31'h0,        ST_OK,    1);
		add_step(CMD_POP,  31'h0,        1, 31'h7FFFFFFF, ST_OK,    0);
		add_step(CMD_POP,  31'h0,        1, 31'h0,        ST_EMPTY, 0);
		add_step(CMD_PUSH, 31'h0,        1, 31'h0,        ST_OK,    1);
		add_step(CMD_PUSH, 31'h7FFFFFFF, 1, 31'h0,        ST_OK,    2);
		add_step(CMD_PUSH, 31'h55555555, 1, 31'h0,        ST_OK,    3);
		add_step(CMD_PUSH, 31'h2AAAAAAA, 1, 31'h0,        ST_OK,    4);
		// Equal values exercise the tie rules of both sifts.
		add_step(CMD_PUSH, 31'd5,        1, 31'h0,        ST_OK,    5);
		add_step(CMD_PUSH, 31'd5,        1, 31'h0,        ST_OK,    6);
		add_step(CMD_PUSH, 31'd5,        1, 31'h0,        ST_OK,    7);
		// Falling values sift up through several levels.
		add_step(CMD_PUSH, 31'd9,        1, 31'h0,        ST_OK,    8);
		add_step(CMD_PUSH, 31'd8,        1, 31'h0,        ST_OK,    9);
		add_step(CMD_PUSH, 31'd7,        1, 31'h0,        ST_OK,    10);
		add_step(CMD_PUSH, 31'd6,        1, 31'h0,        ST_OK,    11);
		add_step(CMD_PUSH, 31'd3,        1, 31'h0,        ST_OK,    12);
		add_step(CMD_POP,  31'h7FFFFFFF, 1, 31'h0,        ST_OK,    11);
		repeat (6)
			add_step(CMD_POP, 31'h0, 0, 31'h0, ST_OK, 0);

		// Reset is held from time zero and released at a clock edge.
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (steps[i])
			send(steps[i].cmd, steps[i].val, steps[i].known, steps[i].want);

		// Random traffic. The share of pushes drifts between segments so that the heap both
		// grows deep and drains back to empty now and then.
		push_pct = 60;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 50 == 0)
				push_pct = $urandom_range(25, 80);
			if ($urandom_range(0, 99) < push_pct)
				send(CMD_PUSH, pick_value(), 0, none);
			else
				send(CMD_POP, value_t'($urandom), 0, none);
		end

		// Drain everything and pop past empty.
		while (heap_fill > 0)
			send(CMD_POP, value_t'($urandom), 0, none);
		repeat (2)
			send(CMD_POP, value_t'($urandom), 0, none);
		cmd_valid <= 1'b0;

		// Wait for every outstanding result, then a little longer to catch stray ones.
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (owed_results.size() != 0) begin
			$error("%0d results never arrived", owed_results.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: min_heap_priority_queue.f
src/mhpq_pkg.sv
src/mhpq_ram.sv
src/min_heap_priority_queue.sv
src/mhpq_checker.sv
sim/tb_top.sv
